// ----- rtl/vpfr_pkg.sv -----
// vpfr_pkg: types and constants for the video packet frame reassembler
// no dependencies; imported by video_packet_frame_reassembler
package vpfr_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 2048;
    localparam int unsigned HEADER_BYTES     = 4;

    localparam int unsigned PLEN_W   = 12;
    localparam int unsigned PNUM_W   = 8;
    localparam int unsigned OFFS_W   = 24;
    localparam int unsigned WLEN_W   = 11;
    localparam int unsigned BYTES_W  = 32;
    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 24'd131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE         = 1'b0,
        REG_FRAME_CAPACITY = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ACT_IGNORED    = 3'd0,
        ACT_STORED     = 3'd1,
        ACT_FRAME_DONE = 3'd2,
        ACT_FRAME_LOST = 3'd3,
        ACT_OVERFLOW   = 3'd4,
        ACT_DROPPED    = 3'd5
    } action_t;

    typedef struct packed {
        logic [PLEN_W-1:0] packet_length;
        logic [PNUM_W-1:0] pkt_number;
        logic              end_of_frame;
        logic              buffer_available;
    } pkt_in_t;

    typedef struct packed {
        action_t           action;
        logic [OFFS_W-1:0] write_offset;
        logic [WLEN_W-1:0] write_length;
        logic [OFFS_W-1:0] frame_length;
        logic [SEQ_W-1:0]  frame_sequence;
    } pkt_out_t;

endpackage

// ----- rtl/video_packet_frame_reassembler.sv -----
// video_packet_frame_reassembler: per-packet frame reassembly tracking
// depends on vpfr_pkg for payload structs, action codes and constants
// an accepted packet is held in in_reg; its result is registered in out_reg
// one packet per cycle while m_ready is high; single compare/add/update path
// reset (aresetn low, synchronous): block disabled, capacity 131072,
// frame state and sequence cleared, both pipeline registers empty
module video_packet_frame_reassembler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [vpfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vpfr_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vpfr_pkg::pkt_in_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output vpfr_pkg::pkt_out_t            m_data
);
    import vpfr_pkg::*;

    logic               enable_reg;
    logic [CFG_W-1:0]   capacity_reg;

    logic               in_valid_reg;
    pkt_in_t            in_reg;
    logic               out_valid_reg;
    pkt_out_t           out_reg;
    pkt_out_t           out_next;

    logic [PNUM_W-1:0]  seen_reg, seen_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;

    logic               advance;
    logic               plen_ok;
    logic               restart;
    logic               num_match;
    logic               over;
    logic [PLEN_W-1:0]  payload;
    logic [PNUM_W-1:0]  seen_base;
    logic [BYTES_W-1:0] bytes_base;
    logic [BYTES_W:0]   sum;
    logic [BYTES_W-1:0] newbytes;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENABLE:         enable_reg   <= cfg_wr_data[0];
                REG_FRAME_CAPACITY: capacity_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // packet evaluation
    always_comb begin
        plen_ok    = enable_reg
                     && (in_reg.packet_length > PLEN_W'(HEADER_BYTES))
                     && ({5'b0, in_reg.packet_length} <= 17'(MAX_PACKET_BYTES));
        payload    = in_reg.packet_length - PLEN_W'(HEADER_BYTES);
        restart    = (in_reg.pkt_number == PNUM_W'(1));
        seen_base  = restart ? '0 : seen_reg;
        bytes_base = restart ? '0 : bytes_reg;
        num_match  = ({1'b0, seen_base} + (PNUM_W+1)'(1)) == {1'b0, in_reg.pkt_number};
        sum        = {1'b0, bytes_base} + (BYTES_W+1)'(payload);
        newbytes   = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
        over       = sum > (BYTES_W+1)'(capacity_reg);

        out_next                = '0;
        out_next.action         = ACT_IGNORED;
        out_next.frame_sequence = seq_reg;
        seen_next               = seen_reg;
        bytes_next              = bytes_reg;
        seq_next                = seq_reg;

        if (plen_ok) begin
            seen_next  = seen_base;
            bytes_next = bytes_base;
            if (num_match) begin
                seen_next  = seen_base + PNUM_W'(1);
                bytes_next = newbytes;
                if (over) begin
                    out_next.action = ACT_OVERFLOW;
                    if (in_reg.end_of_frame) begin
                        out_next.action = ACT_DROPPED;
                        bytes_next      = '0;
                        seq_next        = seq_reg + SEQ_W'(1);
                    end
                end else begin
                    out_next.action       = ACT_STORED;
                    out_next.write_offset = bytes_base[OFFS_W-1:0];
                    out_next.write_length = (payload > PLEN_W'(2047)) ? '1
                                                                      : payload[WLEN_W-1:0];
                    if (in_reg.end_of_frame) begin
                        if (in_reg.buffer_available) begin
                            out_next.action       = ACT_FRAME_DONE;
                            out_next.frame_length = newbytes[OFFS_W-1:0];
                        end else begin
                            out_next.action = ACT_FRAME_LOST;
                        end
                        bytes_next = '0;
                        seq_next   = seq_reg + SEQ_W'(1);
                    end
                end
            end
        end
    end

    // pipeline and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seen_reg      <= '0;
            bytes_reg     <= '0;
            seq_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                seen_reg      <= seen_next;
                bytes_reg     <= bytes_next;
                seq_reg       <= seq_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // checks
    a_seq_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (out_next.action == ACT_FRAME_DONE || out_next.action == ACT_FRAME_LOST
                    || out_next.action == ACT_DROPPED)
        |=> seq_reg == $past(seq_reg) + SEQ_W'(1))
        else $error("sequence did not advance at end of frame");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(seen_reg) && $stable(bytes_reg) && $stable(seq_reg))
        else $error("frame state changed without a transaction");

    a_done_length: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.action == ACT_FRAME_DONE |-> out_reg.frame_length != '0)
        else $error("completed frame reported with zero length");

    a_no_store_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.action == ACT_IGNORED || out_reg.action == ACT_OVERFLOW
                          || out_reg.action == ACT_DROPPED)
        |-> out_reg.write_length == '0 && out_reg.write_offset == '0)
        else $error("write fields set on a packet that was not stored");

endmodule
